// ===== hw/rtl/iba_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package iba_pkg;
    localparam int BLOCKS = 64;
    localparam int FILES  = 32;
    localparam int BW     = $clog2(BLOCKS);
    localparam int FW     = $clog2(FILES);
    localparam int LW     = 7;

    localparam logic [2:0] MODE_CREATE = 3'd0;
    localparam logic [2:0] MODE_DATA   = 3'd1;
    localparam logic [2:0] MODE_READ   = 3'd2;
    localparam logic [2:0] MODE_UPDATE = 3'd3;
    localparam logic [2:0] MODE_DELETE = 3'd4;

    localparam logic [2:0] ST_OK      = 3'd0;
    localparam logic [2:0] ST_FULL    = 3'd1;
    localparam logic [2:0] ST_NOSPACE = 3'd2;
    localparam logic [2:0] ST_NOFILE  = 3'd3;
    localparam logic [2:0] ST_TOOLONG = 3'd4;

    typedef enum logic [13:0] {
        S_IDLE  = 14'b00000000000001,
        S_DATA  = 14'b00000000000010,
        S_CNT   = 14'b00000000000100,
        S_CHK   = 14'b00000000001000,
        S_ALLOC = 14'b00000000010000,
        S_SIZE  = 14'b00000000100000,
        S_RIDX  = 14'b00000001000000,
        S_RBYTE = 14'b00000010000000,
        S_RDAT  = 14'b00000100000000,
        S_ZIDX  = 14'b00001000000000,
        S_ZCLR  = 14'b00010000000000,
        S_MVRD  = 14'b00100000000000,
        S_MVWR  = 14'b01000000000000,
        S_EMIT  = 14'b10000000000000
    } t_state;
endpackage
`default_nettype wire

// ===== hw/rtl/indexed_block_allocator.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Indexed block allocator: a block map with one byte per block and a file
// table whose entries hold an index list of blocks. Files are named by slot.
// Input channel (i_in_valid / o_in_ready) carries commands: create, data
// byte, read, update, delete. Output channel (o_out_valid / i_out_ready)
// carries results; o_last marks the final result of a command.
// One command is worked on at a time; o_in_ready is high only when idle.
// Commands step through the sequencer: a data byte writes one block byte;
// create counts free blocks over the whole map, then allocates; read
// fetches index, byte and result per block; update and delete clear each
// listed block, and delete then moves every later table slot down.
// Results pass through one output register; a stalled receiver holds it,
// and the sequencer waits in its emit state until the register frees up.
// Reset (synchronous, active low) frees all blocks, marks all bytes as
// unwritten so they read as zero, and empties the file table; no clearing pass is needed.
module indexed_block_allocator (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_in_valid,
    output logic                    o_in_ready,
    input  wire logic [2:0]         i_mode,
    input  wire logic [4:0]         i_file_slot,
    input  wire logic [6:0]         i_length,
    input  wire logic [7:0]         i_data_byte,
    output logic                    o_out_valid,
    input  wire logic               i_out_ready,
    output logic [2:0]              o_status,
    output logic [5:0]              o_block_number,
    output logic [7:0]              o_out_byte,
    output logic                    o_last
);
    import iba_pkg::*;

    t_state r_state, n_state, r_ret, n_ret;
    logic [BLOCKS-1:0] r_used, n_used, r_bval, n_bval;
    logic [FW:0]       r_count, n_count;
    logic [BW:0]       r_fpos, n_fpos;
    logic [LW-1:0]     r_frem, n_frem;
    logic [FW-1:0]     r_ffile, n_ffile;
    logic [2:0]        r_mode;
    logic [FW-1:0]     r_slot;
    logic [LW-1:0]     r_len;
    logic [7:0]        r_db;
    logic [BW:0]       r_i, n_i, r_free, n_free, r_n, n_n, r_j, n_j, r_nsz, n_nsz;
    logic [FW-1:0]     r_row, n_row;
    logic [BW-1:0]     r_blk, n_blk;
    logic [2:0]        r_res_st, n_res_st;
    logic [BW-1:0]     r_res_blk, n_res_blk;
    logic [7:0]        r_res_byte, n_res_byte;
    logic              r_res_last, n_res_last;
    logic              r_ovalid;
    logic [2:0]        r_o_st;
    logic [BW-1:0]     r_o_blk;
    logic [7:0]        r_o_byte;
    logic              r_o_last;

    logic [BW-1:0]     mem_idx [FILES*BLOCKS];
    logic [LW-1:0]     mem_sz [FILES];
    logic [7:0]        mem_bb [BLOCKS];
    logic [BW-1:0]     r_idx_q;
    logic [LW-1:0]     r_size_q;
    logic [7:0]        r_bb_q;
    logic              r_bv_q;

    logic              idx_we, sz_we, bb_we;
    logic [FW+BW-1:0]  idx_waddr, idx_raddr;
    logic [BW-1:0]     idx_wdata;
    logic [FW-1:0]     sz_waddr, sz_raddr;
    logic [LW-1:0]     sz_wdata;
    logic [BW-1:0]     bb_waddr, bb_raddr;
    logic              acc, o_free;
    logic [BW-1:0]     ri;

    assign o_in_ready     = (r_state == S_IDLE);
    assign acc            = i_in_valid && o_in_ready;
    assign o_free         = !r_ovalid || i_out_ready;
    assign o_out_valid    = r_ovalid;
    assign o_status       = r_o_st;
    assign o_block_number = r_o_blk;
    assign o_out_byte     = r_o_byte;
    assign o_last         = r_o_last;
    assign ri             = r_i[BW-1:0];

    always_comb begin
        n_state = r_state; n_ret = r_ret;
        n_used = r_used; n_bval = r_bval;
        n_count = r_count; n_fpos = r_fpos; n_frem = r_frem; n_ffile = r_ffile;
        n_i = r_i; n_free = r_free; n_n = r_n; n_j = r_j; n_nsz = r_nsz;
        n_row = r_row; n_blk = r_blk;
        n_res_st = r_res_st; n_res_blk = r_res_blk;
        n_res_byte = r_res_byte; n_res_last = r_res_last;
        idx_we = 1'b0; idx_waddr = {r_row, r_j[BW-1:0]}; idx_wdata = r_idx_q;
        idx_raddr = {r_ffile, r_fpos[BW-1:0]};
        sz_we = 1'b0; sz_waddr = r_row; sz_wdata = r_size_q;
        sz_raddr = i_file_slot[FW-1:0];
        bb_we = 1'b0; bb_waddr = r_idx_q; bb_raddr = r_idx_q;
        unique case (r_state)
            S_IDLE: begin
                if (acc) begin
                    n_res_blk = '0; n_res_byte = '0; n_res_last = 1'b1;
                    n_ret = S_IDLE;
                    priority if (i_mode == MODE_DATA) begin
                        if (r_frem != '0) n_state = S_DATA;
                        else n_frem = '0;
                    end else if (i_mode == MODE_CREATE) begin
                        n_frem = '0; n_fpos = '0;
                        if (r_count >= (FW+1)'(FILES)) begin
                            n_res_st = ST_FULL; n_state = S_EMIT;
                        end else if (i_length == '0) begin
                            n_res_st = ST_NOSPACE; n_state = S_EMIT;
                        end else begin
                            n_i = '0; n_free = '0; n_state = S_CNT;
                        end
                    end else if (i_mode == MODE_READ || i_mode == MODE_UPDATE ||
                                 i_mode == MODE_DELETE) begin
                        n_frem = '0; n_fpos = '0;
                        if ({1'b0, i_file_slot} >= r_count) begin
                            n_res_st = ST_NOFILE; n_state = S_EMIT;
                        end else begin
                            n_state = S_SIZE;
                        end
                    end else begin
                        n_state = S_IDLE;
                    end
                end
            end
            S_DATA: begin
                bb_we = 1'b1;
                n_bval[r_idx_q] = 1'b1;
                n_fpos = r_fpos + 1'b1;
                n_frem = r_frem - 1'b1;
                n_state = S_IDLE;
            end
            S_CNT: begin
                if (!r_used[ri]) n_free = r_free + 1'b1;
                n_i = r_i + 1'b1;
                if (r_i == (BW+1)'(BLOCKS-1)) n_state = S_CHK;
            end
            S_CHK: begin
                if (r_len > r_free) begin
                    n_res_st = ST_NOSPACE; n_state = S_EMIT;
                end else begin
                    n_i = '0; n_n = '0; n_state = S_ALLOC;
                end
            end
            S_ALLOC: begin
                n_i = r_i + 1'b1;
                if (!r_used[ri]) begin
                    n_used[ri] = 1'b1;
                    n_bval[ri] = 1'b0;
                    idx_we = 1'b1;
                    idx_waddr = {r_count[FW-1:0], r_n[BW-1:0]};
                    idx_wdata = ri;
                    n_n = r_n + 1'b1;
                    if (r_n + 1'b1 == r_len) begin
                        sz_we = 1'b1; sz_waddr = r_count[FW-1:0]; sz_wdata = r_len;
                        n_ffile = r_count[FW-1:0]; n_fpos = '0; n_frem = r_len;
                        n_count = r_count + 1'b1;
                        n_res_st = ST_OK; n_state = S_EMIT;
                    end
                end
            end
            S_SIZE: begin
                n_nsz = r_size_q;
                n_j = '0;
                priority if (r_mode == MODE_READ) begin
                    n_state = S_RIDX;
                end else if (r_mode == MODE_UPDATE && r_len > r_size_q) begin
                    n_res_st = ST_TOOLONG; n_state = S_EMIT;
                end else begin
                    n_state = S_ZIDX;
                end
            end
            S_RIDX: begin
                idx_raddr = {r_slot, r_j[BW-1:0]};
                n_state = S_RBYTE;
            end
            S_RBYTE: begin
                n_blk = r_idx_q;
                n_state = S_RDAT;
            end
            S_RDAT: begin
                n_res_st = ST_OK; n_res_blk = r_blk;
                n_res_byte = r_bv_q ? r_bb_q : 8'd0;
                n_res_last = (r_j + 1'b1 == r_nsz);
                n_j = r_j + 1'b1;
                n_ret = (r_j + 1'b1 == r_nsz) ? S_IDLE : S_RIDX;
                n_state = S_EMIT;
            end
            S_ZIDX: begin
                idx_raddr = {r_slot, r_j[BW-1:0]};
                n_state = S_ZCLR;
            end
            S_ZCLR: begin
                n_bval[r_idx_q] = 1'b0;
                if (r_mode == MODE_DELETE) n_used[r_idx_q] = 1'b0;
                n_j = r_j + 1'b1;
                n_state = S_ZIDX;
                if (r_j + 1'b1 == r_nsz) begin
                    n_res_st = ST_OK;
                    priority if (r_mode == MODE_UPDATE) begin
                        n_ffile = r_slot; n_fpos = '0; n_frem = r_len;
                        n_state = S_EMIT;
                    end else if ({1'b0, r_slot} + 1'b1 < r_count) begin
                        n_row = r_slot; n_j = '0; n_state = S_MVRD;
                    end else begin
                        n_count = r_count - 1'b1; n_state = S_EMIT;
                    end
                end
            end
            S_MVRD: begin
                idx_raddr = {r_row + FW'(1), r_j[BW-1:0]};
                sz_raddr = r_row + FW'(1);
                n_state = S_MVWR;
            end
            S_MVWR: begin
                idx_we = 1'b1;
                sz_we = 1'b1;
                n_state = S_MVRD;
                if (r_j == (BW+1)'(BLOCKS-1)) begin
                    n_j = '0;
                    n_row = r_row + FW'(1);
                    if ({1'b0, r_row} + (FW+1)'(2) == r_count) begin
                        n_count = r_count - 1'b1;
                        n_res_st = ST_OK; n_state = S_EMIT;
                    end
                end else begin
                    n_j = r_j + 1'b1;
                end
            end
            S_EMIT: begin
                if (o_free) n_state = r_ret;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_ret   <= S_IDLE;
            r_used  <= '0;
            r_bval  <= '0;
            r_count <= '0;
            r_fpos  <= '0;
            r_frem  <= '0;
            r_ffile <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_ret   <= n_ret;
            r_used  <= n_used;
            r_bval  <= n_bval;
            r_count <= n_count;
            r_fpos  <= n_fpos;
            r_frem  <= n_frem;
            r_ffile <= n_ffile;
            if (r_state == S_EMIT && o_free) r_ovalid <= 1'b1;
            else if (i_out_ready) r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (acc) begin
            r_mode <= i_mode;
            r_slot <= i_file_slot[FW-1:0];
            r_len  <= i_length;
            r_db   <= i_data_byte;
        end
        r_i <= n_i; r_free <= n_free; r_n <= n_n; r_j <= n_j; r_nsz <= n_nsz;
        r_row <= n_row; r_blk <= n_blk;
        r_res_st <= n_res_st; r_res_blk <= n_res_blk;
        r_res_byte <= n_res_byte; r_res_last <= n_res_last;
        if (r_state == S_EMIT && o_free) begin
            r_o_st   <= r_res_st;
            r_o_blk  <= r_res_blk;
            r_o_byte <= r_res_byte;
            r_o_last <= r_res_last;
        end
    end

    // block index lists, file sizes, block bytes
    always_ff @(posedge i_clk) begin
        if (idx_we) mem_idx[idx_waddr] <= idx_wdata;
        r_idx_q <= mem_idx[idx_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (sz_we) mem_sz[sz_waddr] <= sz_wdata;
        r_size_q <= mem_sz[sz_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (bb_we) mem_bb[bb_waddr] <= r_db;
        r_bb_q <= mem_bb[bb_raddr];
        r_bv_q <= r_bval[bb_raddr];
    end
endmodule
`default_nettype wire

// ===== tb/tb_indexed_block_allocator.sv =====
`timescale 1ns / 1ps
module tb_indexed_block_allocator;
    import iba_pkg::*;

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       i_in_valid = 1'b0;
    logic       o_in_ready;
    logic [2:0] i_mode = '0;
    logic [4:0] i_file_slot = '0;
    logic [6:0] i_length = '0;
    logic [7:0] i_data_byte = '0;
    logic       o_out_valid;
    logic       i_out_ready = 1'b0;
    logic [2:0] o_status;
    logic [5:0] o_block_number;
    logic [7:0] o_out_byte;
    logic       o_last;

    indexed_block_allocator dut (.*);

    always #4 i_clk = ~i_clk;

    typedef struct packed {
        logic [2:0] status;
        logic [5:0] blk;
        logic [7:0] val;
        logic       last;
    } result_t;

    typedef struct {
        logic [2:0] mode;
        logic [4:0] slot;
        logic [6:0] len;
        logic [7:0] dbyte;
        bit         has_status;
        logic [2:0] status;
    } cmd_t;

    // disk and file table shadow
    bit        used_map[BLOCKS];
    logic [7:0] disk_byte[BLOCKS];
    logic [5:0] idx_list[FILES][BLOCKS];
    int        fsize[FILES];
    int        nfiles, fill_pos, fill_left, fill_slot;

    result_t   pending_q[$];
    int        errors = 0;
    bit        hold_off = 0;
    int        idle_cycles = 0;

    task automatic push_result(logic [2:0] st, logic [5:0] b, logic [7:0] v, logic l);
        result_t r;
        r.status = st; r.blk = b; r.val = v; r.last = l;
        pending_q.push_back(r);
    endtask

    task automatic allocator_predict(cmd_t c);
        int freecnt, n, j, i;
        if (c.mode > MODE_DELETE) return;
        if (c.mode == MODE_DATA) begin
            if (fill_left > 0 && fill_slot < nfiles && fill_pos < fsize[fill_slot]) begin
                disk_byte[idx_list[fill_slot][fill_pos]] = c.dbyte;
                fill_pos++;
                fill_left--;
            end else
                fill_left = 0;
            return;
        end
        fill_left = 0;
        fill_pos = 0;
        if (c.mode == MODE_CREATE) begin
            freecnt = 0;
            if (nfiles >= FILES) begin
                push_result(ST_FULL, 6'd0, 8'd0, 1'b1);
                return;
            end
            foreach (used_map[k]) if (!used_map[k]) freecnt++;
            if (c.len == 0 || c.len > freecnt) begin
                push_result(ST_NOSPACE, 6'd0, 8'd0, 1'b1);
                return;
            end
            n = 0;
            for (i = 0; i < BLOCKS && n < c.len; i++)
                if (!used_map[i]) begin
                    used_map[i] = 1;
                    disk_byte[i] = 8'd0;
                    idx_list[nfiles][n] = 6'(i);
                    n++;
                end
            fsize[nfiles] = c.len;
            fill_slot = nfiles;
            fill_left = c.len;
            nfiles++;
            push_result(ST_OK, 6'd0, 8'd0, 1'b1);
            return;
        end
        if (c.slot >= nfiles) begin
            push_result(ST_NOFILE, 6'd0, 8'd0, 1'b1);
            return;
        end
        n = fsize[c.slot];
        if (c.mode == MODE_READ) begin
            for (j = 0; j < n; j++)
                push_result(ST_OK, idx_list[c.slot][j], disk_byte[idx_list[c.slot][j]],
                            j + 1 == n);
        end else if (c.mode == MODE_UPDATE) begin
            if (c.len > n) begin
                push_result(ST_TOOLONG, 6'd0, 8'd0, 1'b1);
                return;
            end
            for (j = 0; j < n; j++) disk_byte[idx_list[c.slot][j]] = 8'd0;
            fill_slot = c.slot;
            fill_left = c.len;
            push_result(ST_OK, 6'd0, 8'd0, 1'b1);
        end else begin
            for (j = 0; j < n; j++) begin
                disk_byte[idx_list[c.slot][j]] = 8'd0;
                used_map[idx_list[c.slot][j]] = 0;
            end
            for (i = c.slot; i + 1 < nfiles; i++) begin
                idx_list[i] = idx_list[i + 1];
                fsize[i] = fsize[i + 1];
            end
            nfiles--;
            push_result(ST_OK, 6'd0, 8'd0, 1'b1);
        end
    endtask

    // sends one beat; typed status is checked against the predictor's first result.
    // ready seen at a falling edge holds until the next rising edge
    task automatic send_cmd(cmd_t c);
        int qn;
        if ($urandom_range(0, 3) == 0)
            repeat ($urandom_range(1, 6)) @(negedge i_clk);
        qn = pending_q.size();
        allocator_predict(c);
        if (c.has_status && pending_q.size() > qn && pending_q[qn].status != c.status) begin
            $display("%0t ERROR table status exp=%0d act=%0d", $time, c.status,
                     pending_q[qn].status);
            errors++;
        end
        i_mode = c.mode; i_file_slot = c.slot; i_length = c.len; i_data_byte = c.dbyte;
        i_in_valid = 1'b1;
        while (!o_in_ready) @(negedge i_clk);
        @(negedge i_clk);
        i_in_valid = 1'b0;
    endtask

    function automatic cmd_t mk(logic [2:0] m, logic [4:0] s, logic [6:0] l, logic [7:0] d,
                                bit hs = 0, logic [2:0] st = ST_OK);
        cmd_t c;
        c.mode = m; c.slot = s; c.len = l; c.dbyte = d; c.has_status = hs; c.status = st;
        return c;
    endfunction

    // output checker and watchdog
    always @(posedge i_clk) begin
        result_t got, want;
        if (i_rst_n) begin
            if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (o_out_valid && i_out_ready) begin
                got = {o_status, o_block_number, o_out_byte, o_last};
                if (pending_q.size() == 0) begin
                    $display("%0t ERROR unexpected beat act=%h", $time, got);
                    errors++;
                end else begin
                    want = pending_q.pop_front();
                    if (got != want) begin
                        $display("%0t ERROR exp st=%0d blk=%0d byte=%0d last=%0d",
                                 $time, want.status, want.blk, want.val, want.last);
                        $display("%0t ERROR act st=%0d blk=%0d byte=%0d last=%0d",
                                 $time, got.status, got.blk, got.val, got.last);
                        errors++;
                    end
                end
            end
            if (idle_cycles > 20000) begin
                $display("DONE: errors detected");
                $finish;
            end
        end
    end

    // receiver stall pattern, with one long hold-off
    initial begin
        int ph;
        ph = 0;
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            ph++;
            if (hold_off)
                i_out_ready <= 1'b0;
            else if ((ph / 64) % 3 == 0)
                i_out_ready <= 1'b1;
            else
                i_out_ready <= ($urandom_range(0, 3) != 0);
        end
    end

    initial begin
        cmd_t tbl[$];
        int r, n, k, nd;
        foreach (used_map[k2]) begin used_map[k2] = 0; disk_byte[k2] = 0; end
        nfiles = 0; fill_pos = 0; fill_left = 0; fill_slot = 0;
        repeat (12) @(negedge i_clk);
        i_rst_n = 1'b1;

        tbl.push_back(mk(MODE_READ, 0, 0, 0, 1, ST_NOFILE));
        tbl.push_back(mk(MODE_UPDATE, 31, 0, 0, 1, ST_NOFILE));
        tbl.push_back(mk(MODE_DELETE, 0, 0, 0, 1, ST_NOFILE));
        tbl.push_back(mk(MODE_CREATE, 0, 0, 0, 1, ST_NOSPACE));
        tbl.push_back(mk(MODE_CREATE, 0, 65, 0, 1, ST_NOSPACE));
        tbl.push_back(mk(MODE_DATA, 0, 0, 8'hff));
        tbl.push_back(mk(MODE_CREATE, 0, 3, 0, 1, ST_OK));
        tbl.push_back(mk(MODE_DATA, 0, 0, 8'hff));
        tbl.push_back(mk(MODE_DATA, 0, 0, 8'h00));
        tbl.push_back(mk(MODE_DATA, 0, 0, 8'ha5));
        tbl.push_back(mk(MODE_DATA, 0, 0, 8'h5a));
        tbl.push_back(mk(MODE_READ, 0, 0, 0));
        tbl.push_back(mk(3'd5, 0, 0, 0));
        tbl.push_back(mk(3'd7, 31, 127, 8'hff));
        tbl.push_back(mk(MODE_UPDATE, 0, 4, 0, 1, ST_TOOLONG));
        tbl.push_back(mk(MODE_UPDATE, 0, 2, 0, 1, ST_OK));
        tbl.push_back(mk(MODE_DATA, 0, 0, 8'h81));
        tbl.push_back(mk(MODE_READ, 0, 0, 0));
        tbl.push_back(mk(MODE_UPDATE, 0, 0, 0, 1, ST_OK));
        tbl.push_back(mk(MODE_CREATE, 0, 61, 0, 1, ST_OK));
        tbl.push_back(mk(MODE_CREATE, 0, 1, 0, 1, ST_NOSPACE));
        tbl.push_back(mk(MODE_READ, 1, 0, 0));
        tbl.push_back(mk(MODE_DELETE, 0, 0, 0, 1, ST_OK));
        tbl.push_back(mk(MODE_DELETE, 0, 0, 0, 1, ST_OK));
        foreach (tbl[t]) send_cmd(tbl[t]);

        // fill the table to capacity with one-block files
        for (k = 0; k < FILES; k++) send_cmd(mk(MODE_CREATE, 0, 1, 8'hff));
        send_cmd(mk(MODE_CREATE, 0, 1, 0, 1, ST_FULL));
        send_cmd(mk(MODE_READ, 31, 0, 0));
        // long receiver hold-off while reads pile up
        fork
            begin
                hold_off = 1;
                repeat (300) @(negedge i_clk);
                hold_off = 0;
            end
            for (k = 0; k < 8; k++) send_cmd(mk(MODE_READ, 5'(k), 0, 0));
        join
        for (k = 0; k < FILES; k++)
            send_cmd(mk(MODE_DELETE, 5'($urandom_range(0, FILES - 1 - k)), 0, 0));

        for (r = 0; r < 60; r++) begin
            k = $urandom_range(0, 99);
            if (k < 35) begin
                n = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 127) : $urandom_range(1, 8);
                send_cmd(mk(MODE_CREATE, 5'($urandom), 7'(n), 8'($urandom)));
                nd = $urandom_range(0, n + 1);
                for (int b = 0; b < nd; b++)
                    send_cmd(mk(MODE_DATA, 5'($urandom), 7'($urandom), 8'($urandom)));
            end else if (k < 55) begin
                send_cmd(mk(MODE_READ, 5'($urandom_range(0, nfiles + 1)), 7'($urandom),
                            8'($urandom)));
            end else if (k < 72) begin
                n = $urandom_range(0, 10);
                send_cmd(mk(MODE_UPDATE, 5'($urandom_range(0, nfiles + 1)), 7'(n),
                            8'($urandom)));
                nd = $urandom_range(0, n + 1);
                for (int b = 0; b < nd; b++)
                    send_cmd(mk(MODE_DATA, 5'($urandom), 7'($urandom), 8'($urandom)));
            end else if (k < 90 || nfiles > 12) begin
                send_cmd(mk(MODE_DELETE, 5'($urandom_range(0, nfiles)), 7'($urandom),
                            8'($urandom)));
            end else if (k < 95) begin
                send_cmd(mk(MODE_DATA, 5'($urandom), 7'($urandom), 8'($urandom)));
            end else begin
                send_cmd(mk(3'($urandom_range(5, 7)), 5'($urandom), 7'($urandom),
                            8'($urandom)));
            end
        end
        while (pending_q.size() != 0) @(posedge i_clk);
        repeat (500) @(posedge i_clk);
        if (errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end
endmodule
